FILE: design/svm_pkg.sv
// Shared types and constants for the sparse vector merge block.
// No dependencies; compile this file first.
`default_nettype none

package svm_pkg;

    localparam int MAX_LEN    = 16;
    localparam int VALUE_BITS = 16;
    localparam int IDX_W      = 4;                  // bits of a stored position
    localparam int CNT_W      = 5;                  // counts 0..MAX_LEN
    localparam int RES_W      = 32;
    localparam int ENTRY_W    = IDX_W + VALUE_BITS; // index/value pair

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_FIN
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_MUL
    } alu_op_t;

endpackage

`default_nettype wire

FILE: design/svm_in_if.sv
// Input channel: one dense vector element per beat.
// Depends on svm_pkg for the value width.
`default_nettype none

interface svm_in_if;
    logic                                valid;
    logic                                ready;
    logic                                vector_sel;
    logic signed [svm_pkg::VALUE_BITS-1:0] value;
    logic                                last;

    modport source (output valid, output vector_sel, output value, output last,
                    input ready);
    modport sink   (input valid, input vector_sel, input value, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: design/svm_out_if.sv
// Output channel: one merged result entry per beat.
// Depends on svm_pkg for the index and result widths.
`default_nettype none

interface svm_out_if;
    logic                              valid;
    logic                              ready;
    logic [svm_pkg::IDX_W-1:0]         index;
    logic signed [svm_pkg::RES_W-1:0]  result_value;
    logic                              present;
    logic                              end_of_run;

    modport source (output valid, output index, output result_value,
                    output present, output end_of_run, input ready);
    modport sink   (input valid, input index, input result_value,
                    input present, input end_of_run, output ready);
endinterface

`default_nettype wire

FILE: design/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module svm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/svm_alu.sv
// Shared arithmetic unit of the merge: add or multiply two stored values.
// Depends on svm_pkg for widths and the operation code.
`default_nettype none

module svm_alu (
    input  wire svm_pkg::alu_op_t                  op,
    input  wire logic signed [svm_pkg::VALUE_BITS-1:0] a,
    input  wire logic signed [svm_pkg::VALUE_BITS-1:0] b,
    output logic signed [svm_pkg::RES_W-1:0]           res
);

    logic signed [2*svm_pkg::VALUE_BITS-1:0] prod;
    logic signed [svm_pkg::VALUE_BITS:0]     sum;

    assign prod = a * b;
    assign sum  = {a[svm_pkg::VALUE_BITS-1], a} + {b[svm_pkg::VALUE_BITS-1], b};

    always_comb
    begin
        case (op)
            svm_pkg::ALU_ADD: res = svm_pkg::RES_W'(sum);
            svm_pkg::ALU_MUL: res = svm_pkg::RES_W'(prod);
            default:          res = svm_pkg::RES_W'(sum);
        endcase
    end

endmodule

`default_nettype wire

FILE: design/sparse_vector_merge_add_mul.sv
// Top level of the sparse vector merge: loader, merge sequencer, output register.
// Depends on svm_pkg, svm_in_if, svm_out_if, svm_ram and svm_alu.
`default_nettype none

// Two dense vectors arrive as beats on in_ch, A (vector_sel=0) then B
// (vector_sel=1); a shared position counter numbers the elements and only
// nonzero ones are kept as index/value pairs in two 16-entry RAMs. The
// beat marked last for B starts the merge, during which in_ch is not
// ready: every merge step passes through ST_READ, which presents the RAM
// read addresses, and ST_CALC, which compares the indices, runs the
// shared add/multiply unit and holds while the held-back result cannot
// move on to out_ch. A run has at most count_a + count_b steps, then
// ST_FIN. In sum mode (mode=0) every index with a nonzero sum is
// emitted, an index held by one vector alone with its own value; in
// product mode (mode=1) only indices held by both give a product. One
// result is held back until the next is known, so that end_of_run marks
// the true last beat; an empty run gives a single beat with present=0.
// Counts and position clear at the end of each run. Write mode only while
// the block is idle.

module sparse_vector_merge_add_mul (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    svm_in_if.sink         in_ch,
    svm_out_if.source      out_ch
);

    localparam int IW = svm_pkg::IDX_W;
    localparam int VB = svm_pkg::VALUE_BITS;
    localparam int CW = svm_pkg::CNT_W;
    localparam int RW = svm_pkg::RES_W;
    localparam int EW = svm_pkg::ENTRY_W;

    svm_pkg::state_t state_reg, state_next;

    logic          mode_reg;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] n_reg, n_next;

    // Held-back result
    logic                 pend_valid_reg, pend_valid_next;
    logic [IW-1:0]        pend_index_reg, pend_index_next;
    logic signed [RW-1:0] pend_value_reg, pend_value_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [IW-1:0]        out_index_reg, out_index_next;
    logic signed [RW-1:0] out_value_reg, out_value_next;
    logic                 out_present_reg, out_present_next;
    logic                 out_end_reg, out_end_next;

    // Loader
    logic          in_acc;
    logic          load_ok;
    logic          we_a, we_b;
    logic [EW-1:0] wr_entry;

    // Merge datapath
    logic [EW-1:0]        rd_a, rd_b;
    logic [IW-1:0]        ia, ib;
    logic signed [VB-1:0] va, vb;
    logic                 have_a, have_b, room;
    logic                 both, tail_a, tail_b, work;
    logic                 eq, lt, take_b;
    logic                 emit, adv_i, adv_j;
    logic                 out_free, stall;
    logic [IW-1:0]        emit_index;
    svm_pkg::alu_op_t     alu_op;
    logic signed [VB-1:0] alu_a, alu_b;
    logic signed [RW-1:0] alu_res;

    // ---------------------------------------------------------------
    // Loader: keep nonzero elements at the current position
    // ---------------------------------------------------------------
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign load_ok  = in_acc && (pos_reg < CW'(svm_pkg::MAX_LEN)) && (in_ch.value != '0);
    assign we_a     = load_ok && !in_ch.vector_sel && (cnt_a_reg < CW'(svm_pkg::MAX_LEN));
    assign we_b     = load_ok && in_ch.vector_sel && (cnt_b_reg < CW'(svm_pkg::MAX_LEN));
    assign wr_entry = {pos_reg[IW-1:0], in_ch.value};

    svm_ram #(
        .WIDTH (EW),
        .DEPTH (svm_pkg::MAX_LEN)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[IW-1:0]),
        .wdata (wr_entry),
        .raddr (i_reg[IW-1:0]),
        .rdata (rd_a)
    );

    svm_ram #(
        .WIDTH (EW),
        .DEPTH (svm_pkg::MAX_LEN)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[IW-1:0]),
        .wdata (wr_entry),
        .raddr (j_reg[IW-1:0]),
        .rdata (rd_b)
    );

    // ---------------------------------------------------------------
    // Merge step decode
    // ---------------------------------------------------------------
    assign ia = rd_a[EW-1:VB];
    assign va = rd_a[VB-1:0];
    assign ib = rd_b[EW-1:VB];
    assign vb = rd_b[VB-1:0];

    assign have_a = i_reg < cnt_a_reg;
    assign have_b = j_reg < cnt_b_reg;
    assign room   = n_reg < CW'(svm_pkg::MAX_LEN);

    // Both lists open first; in sum mode drain A, then B
    assign both   = have_a && have_b && room;
    assign tail_a = !both && !mode_reg && have_a && room;
    assign tail_b = !both && !mode_reg && !have_a && have_b && room;
    assign work   = both || tail_a || tail_b;

    assign eq     = ia == ib;
    assign lt     = ia < ib;
    assign take_b = (both && !eq && !lt) || tail_b;

    // Matching indices use both values; a lone entry adds zero
    assign alu_op     = (both && eq && mode_reg) ? svm_pkg::ALU_MUL : svm_pkg::ALU_ADD;
    assign alu_a      = take_b ? vb : va;
    assign alu_b      = (both && eq) ? vb : '0;
    assign emit_index = take_b ? ib : ia;

    svm_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign emit  = both ? (eq ? (mode_reg || (alu_res != '0)) : !mode_reg) : 1'b1;
    assign adv_i = both ? (eq || lt) : tail_a;
    assign adv_j = both ? (eq || !lt) : tail_b;

    assign out_free = !out_valid_reg || out_ch.ready;
    // Hold the step while the held-back result cannot move on
    assign stall    = emit && pend_valid_reg && !out_free;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            svm_pkg::ST_IDLE:
            begin
                if (in_acc && in_ch.last && in_ch.vector_sel)
                begin
                    state_next = svm_pkg::ST_READ;
                end
            end
            svm_pkg::ST_READ:
            begin
                state_next = work ? svm_pkg::ST_CALC : svm_pkg::ST_FIN;
            end
            svm_pkg::ST_CALC:
            begin
                if (!stall)
                begin
                    state_next = svm_pkg::ST_READ;
                end
            end
            svm_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = svm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = svm_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        pos_next         = pos_reg;
        cnt_a_next       = cnt_a_reg;
        cnt_b_next       = cnt_b_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        n_next           = n_reg;
        pend_valid_next  = pend_valid_reg;
        pend_index_next  = pend_index_reg;
        pend_value_next  = pend_value_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_index_next   = out_index_reg;
        out_value_next   = out_value_reg;
        out_present_next = out_present_reg;
        out_end_next     = out_end_reg;

        case (state_reg)
            svm_pkg::ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                n_next = '0;
                if (in_acc)
                begin
                    if (we_a)
                    begin
                        cnt_a_next = cnt_a_reg + 1'b1;
                    end
                    if (we_b)
                    begin
                        cnt_b_next = cnt_b_reg + 1'b1;
                    end
                    // Saturate the position at MAX_LEN
                    if (pos_reg < CW'(svm_pkg::MAX_LEN))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (in_ch.last && !in_ch.vector_sel)
                    begin
                        pos_next = '0;
                    end
                end
            end
            svm_pkg::ST_CALC:
            begin
                if (!stall)
                begin
                    if (adv_i)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    if (adv_j)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    if (emit)
                    begin
                        // Release the previous result, not the last one
                        if (pend_valid_reg)
                        begin
                            out_valid_next   = 1'b1;
                            out_index_next   = pend_index_reg;
                            out_value_next   = pend_value_reg;
                            out_present_next = 1'b1;
                            out_end_next     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_index_next = emit_index;
                        pend_value_next = alu_res;
                        n_next          = n_reg + 1'b1;
                    end
                end
            end
            svm_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_end_next     = 1'b1;
                    out_present_next = pend_valid_reg;
                    out_index_next   = pend_valid_reg ? pend_index_reg : '0;
                    out_value_next   = pend_valid_reg ? pend_value_reg : '0;
                    // Drop both lists for the next pair
                    pend_valid_next  = 1'b0;
                    cnt_a_next       = '0;
                    cnt_b_next       = '0;
                    pos_next         = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ch.ready         = state_reg == svm_pkg::ST_IDLE;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.index        = out_index_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.present      = out_present_reg;
    assign out_ch.end_of_run   = out_end_reg;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= svm_pkg::ST_IDLE;
            mode_reg       <= 1'b0;
            pos_reg        <= '0;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_index_reg  <= pend_index_next;
        pend_value_reg  <= pend_value_next;
        out_index_reg   <= out_index_next;
        out_value_reg   <= out_value_next;
        out_present_reg <= out_present_next;
        out_end_reg     <= out_end_next;
    end

endmodule

`default_nettype wire

FILE: tb/sv/svm_merge_checker.sv
`timescale 1ns / 1ps
// Checker for the sparse vector merge: watches both channels and the mode port,
// predicts every merged entry and compares it with what the block emits.
// Depends on svm_pkg, svm_in_if and svm_out_if.

module svm_merge_checker
    import svm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    svm_in_if         in_ch,
    svm_out_if        out_ch,
    output int        errors,
    output int        pending
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [RES_W-1:0] result_value;
        logic                    present;
        logic                    end_of_run;
    } merge_entry_t;

    // Predicted copy of the two sparse lists and the shared position
    logic [IDX_W-1:0]             a_idx [MAX_LEN];
    logic signed [VALUE_BITS-1:0] a_val [MAX_LEN];
    logic [IDX_W-1:0]             b_idx [MAX_LEN];
    logic signed [VALUE_BITS-1:0] b_val [MAX_LEN];
    int unsigned                  a_cnt;
    int unsigned                  b_cnt;
    int unsigned                  next_pos;
    alu_op_t                      mode_op;
    merge_entry_t                 expected_entries [$];
    int                           beats_seen;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] result beat %0d: %s", $realtime, beats_seen, what);
    endtask

    function automatic void add_entry(ref merge_entry_t run_q [$],
                                      input logic [IDX_W-1:0] idx,
                                      input logic signed [RES_W-1:0] v);
        run_q.push_back('{index: idx, result_value: v, present: 1'b1, end_of_run: 1'b0});
    endfunction

    // Walk both lists in step; the run stops after MAX_LEN entries
    function automatic void merge_lists();
        merge_entry_t            run_q [$];
        merge_entry_t            tail;
        int unsigned             i;
        int unsigned             j;
        logic signed [RES_W-1:0] ea;
        logic signed [RES_W-1:0] eb;
        i = 0;
        j = 0;
        while (i < a_cnt && j < b_cnt && run_q.size() < MAX_LEN)
        begin
            ea = RES_W'(a_val[i]);
            eb = RES_W'(b_val[j]);
            if (a_idx[i] == b_idx[j])
            begin
                if (mode_op == ALU_ADD)
                begin
                    if ((ea + eb) != 0)
                        add_entry(run_q, a_idx[i], ea + eb);
                end
                else
                    add_entry(run_q, a_idx[i], ea * eb);
                i++;
                j++;
            end
            else if (a_idx[i] < b_idx[j])
            begin
                if (mode_op == ALU_ADD)
                    add_entry(run_q, a_idx[i], ea);
                i++;
            end
            else
            begin
                if (mode_op == ALU_ADD)
                    add_entry(run_q, b_idx[j], eb);
                j++;
            end
        end
        if (mode_op == ALU_ADD)
        begin
            while (i < a_cnt && run_q.size() < MAX_LEN)
            begin
                ea = RES_W'(a_val[i]);
                add_entry(run_q, a_idx[i], ea);
                i++;
            end
            while (j < b_cnt && run_q.size() < MAX_LEN)
            begin
                eb = RES_W'(b_val[j]);
                add_entry(run_q, b_idx[j], eb);
                j++;
            end
        end
        if (run_q.size() == 0)
            run_q.push_back('{index: '0, result_value: '0, present: 1'b0, end_of_run: 1'b0});
        tail = run_q.pop_back();
        tail.end_of_run = 1'b1;
        run_q.push_back(tail);
        foreach (run_q[k])
            expected_entries.push_back(run_q[k]);
    endfunction

    function automatic void take_element(input logic sel,
                                         input logic signed [VALUE_BITS-1:0] v,
                                         input logic lst);
        if (next_pos < MAX_LEN)
        begin
            if (v != 0)
            begin
                if (sel == 1'b0 && a_cnt < MAX_LEN)
                begin
                    a_idx[a_cnt] = next_pos[IDX_W-1:0];
                    a_val[a_cnt] = v;
                    a_cnt++;
                end
                else if (sel == 1'b1 && b_cnt < MAX_LEN)
                begin
                    b_idx[b_cnt] = next_pos[IDX_W-1:0];
                    b_val[b_cnt] = v;
                    b_cnt++;
                end
            end
            next_pos++;
        end
        if (lst)
        begin
            if (sel == 1'b0)
                next_pos = 0;
            else
            begin
                merge_lists();
                a_cnt    = 0;
                b_cnt    = 0;
                next_pos = 0;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        merge_entry_t want;
        if (!rst_n)
        begin
            a_cnt      = 0;
            b_cnt      = 0;
            next_pos   = 0;
            mode_op    = ALU_ADD;
            beats_seen = 0;
            errors     = 0;
            expected_entries.delete();
        end
        else
        begin
            if (cfg_we)
                mode_op = alu_op_t'(cfg_wdata);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_entries.size() == 0)
                    report_mismatch($sformatf("unexpected result: index %0d value %0d",
                                              out_ch.index, out_ch.result_value));
                else
                begin
                    want = expected_entries.pop_front();
                    if (out_ch.index !== want.index)
                        report_mismatch($sformatf("index: got %0d, expected %0d",
                                                  out_ch.index, want.index));
                    if (out_ch.result_value !== want.result_value)
                        report_mismatch($sformatf("result_value: got %0d, expected %0d",
                                                  out_ch.result_value, want.result_value));
                    if (out_ch.present !== want.present)
                        report_mismatch($sformatf("present: got %b, expected %b",
                                                  out_ch.present, want.present));
                    if (out_ch.end_of_run !== want.end_of_run)
                        report_mismatch($sformatf("end_of_run: got %b, expected %b",
                                                  out_ch.end_of_run, want.end_of_run));
                end
                beats_seen++;
            end
            if (in_ch.valid && in_ch.ready)
                take_element(in_ch.vector_sel, in_ch.value, in_ch.last);
        end
        pending = expected_entries.size();
    end

endmodule

FILE: tb/sv/tb_sparse_vector_merge_add_mul.sv
`timescale 1ns / 1ps
// Testbench top for the sparse vector merge: clock, reset, stimulus and verdict.
// Depends on svm_pkg, both channel interfaces, the block and svm_merge_checker.

module tb_sparse_vector_merge_add_mul;
    import svm_pkg::*;

    localparam int  TOTAL_ITEMS    = 360;
    localparam int  RUNS_PER_PHASE = 6;
    localparam int  SETTLE_CYCLES  = 8;     // lets the block return to idle after its last beat
    localparam int  DRAIN_CYCLES   = 10;
    localparam int  HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int  WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // Shapes of one A/B pair in the random part
    typedef enum int {
        RUN_PLAIN,      // A then B, short vectors, some cancelling entries
        RUN_LONG,       // at least one vector runs past MAX_LEN
        RUN_MIXED,      // A and B elements interleaved, stray A last marks
        RUN_RESTART,    // A restarted several times, so store A is out of order
        RUN_KINDS
    } run_kind_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   check_errors;
    int   pending;
    int   items_sent  = 0;
    int   in_idle_pct = 20;
    int   out_beats   = 0;
    int   quiet_cycles = 0;
    logic in_stalled  = 1'b0;

    svm_in_if  in_ch ();
    svm_out_if out_ch ();

    sparse_vector_merge_add_mul u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    svm_merge_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .errors   (check_errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle gap before a beat: none unless drawn at idle_pct, then mostly short, now and then long
    function automatic int pick_gap(input int idle_pct);
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) < 8)
            return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    // Idle rate for the next stretch; zero gives stretches with no idling at all
    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 20;
            default: return 60;
        endcase
    endfunction

    // Dense element: zeros at the given rate, else small, full-range or extreme values
    function automatic logic signed [VALUE_BITS-1:0] pick_value(input int zero_pct);
        logic signed [VALUE_BITS-1:0] s;
        if ($urandom_range(99) < zero_pct)
            return '0;
        case ($urandom_range(2))
            0:
            begin
                s = VALUE_BITS'($urandom_range(8));
                s = s - 16'sd4;
            end
            1: s = VALUE_BITS'($urandom);
            default:
            begin
                case ($urandom_range(5))
                    0:       s = 16'sh7FFF;
                    1:       s = 16'sh8000;
                    2:       s = 16'sh0001;
                    3:       s = 16'shFFFF;
                    4:       s = 16'sh5555;
                    default: s = 16'shAAAA;
                endcase
            end
        endcase
        return s;
    endfunction

    // Offer one element and hold it until the block takes the beat.
    // Entered and left at a falling edge; valid stays high when no gap follows.
    task automatic send_elem(input logic sel, input logic signed [VALUE_BITS-1:0] v,
                             input logic lst);
        int gap;
        gap = pick_gap(in_idle_pct);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.vector_sel = sel;
        in_ch.value      = v;
        in_ch.last       = lst;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // A then B; B copies the negated A element at the same position at cancel_pct
    task automatic send_pair(input int len_a, input int len_b, input int zero_pct,
                             input int cancel_pct);
        logic signed [VALUE_BITS-1:0] a_vals [$];
        logic signed [VALUE_BITS-1:0] v;
        for (int i = 0; i < len_a; i++)
        begin
            v = pick_value(zero_pct);
            a_vals.push_back(v);
            send_elem(SEL_A, v, i == len_a - 1);
        end
        for (int i = 0; i < len_b; i++)
        begin
            if (i < a_vals.size() && $urandom_range(99) < cancel_pct)
                v = -a_vals[i];
            else
                v = pick_value(zero_pct);
            send_elem(SEL_B, v, i == len_b - 1);
        end
    endtask

    // Write the mode only once the block has gone idle: drop valid, let every
    // predicted entry arrive, then give the block time to finish its run
    task automatic set_mode(input alu_op_t op);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = (op == ALU_MUL);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Count output beats, note when the block refuses an offered beat while a
    // result waits, and watch for a run in which nothing moves any more
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            out_beats <= out_beats + 1;
        in_stalled <= out_ch.valid && in_ch.valid && !in_ch.ready;
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random back-pressure in stretches, plus two long hold-offs taken
    // while the sender is being refused, so that the block backs up onto its input
    initial
    begin : receiver
        int gap_left;
        int idle_pct;
        int cycle_no;
        int holds_done;
        gap_left   = 0;
        idle_pct   = 0;
        cycle_no   = 0;
        holds_done = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cycle_no++;
            if (cycle_no % 64 == 0)
                idle_pct = pick_idle_pct();
            if (holds_done < 2 && in_stalled &&
                out_beats >= ((holds_done == 0) ? 30 : 200))
            begin
                out_ch.ready = 1'b0;
                holds_done++;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (gap_left > 0)
            begin
                out_ch.ready = 1'b0;
                gap_left--;
            end
            else
            begin
                gap_left = pick_gap(idle_pct);
                out_ch.ready = (gap_left == 0);
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    initial
    begin : stimulus
        int        run;
        int        phase;
        int        len_a;
        int        len_b;
        int        n;
        int        segs;
        logic      sel;
        run_kind_t kind;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.vector_sel = SEL_A;
        in_ch.value      = '0;
        in_ch.last       = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Sum mode from reset: lone entries from each side, the most negative
        // sum, and a position where A and B cancel to nothing
        send_elem(SEL_A, 16'sh7FFF, 1'b0);
        send_elem(SEL_A, 16'sh0000, 1'b0);
        send_elem(SEL_A, 16'sh8000, 1'b0);
        send_elem(SEL_A, 16'sh0005, 1'b1);
        send_elem(SEL_B, 16'sh0000, 1'b0);
        send_elem(SEL_B, 16'sh0007, 1'b0);
        send_elem(SEL_B, 16'sh8000, 1'b0);
        send_elem(SEL_B, 16'shFFFB, 1'b1);
        // Two all-zero vectors: empty result list
        send_elem(SEL_A, 16'sh0000, 1'b1);
        send_elem(SEL_B, 16'sh0000, 1'b1);

        // Product mode: largest product, indices held by one side only
        set_mode(ALU_MUL);
        send_elem(SEL_A, 16'sh8000, 1'b0);
        send_elem(SEL_A, 16'sh0003, 1'b0);
        send_elem(SEL_A, 16'sh0000, 1'b1);
        send_elem(SEL_B, 16'sh8000, 1'b0);
        send_elem(SEL_B, 16'sh0000, 1'b0);
        send_elem(SEL_B, 16'sh0009, 1'b1);
        // No common index: empty result list in product mode
        send_elem(SEL_A, 16'sh0000, 1'b1);
        send_elem(SEL_B, 16'shFFFF, 1'b1);

        // Random pairs in phases; every shape is taken once before drawing at random
        run = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (run % RUNS_PER_PHASE == 0)
            begin
                phase = run / RUNS_PER_PHASE;
                if (phase == 1 || (phase > 1 && $urandom_range(1) == 1))
                    set_mode(ALU_MUL);
                else
                    set_mode(ALU_ADD);
            end
            in_idle_pct = pick_idle_pct();
            if (run < RUN_KINDS)
                kind = run_kind_t'(run);
            else
                kind = run_kind_t'($urandom_range(RUN_KINDS - 1));
            case (kind)
                RUN_PLAIN:
                begin
                    len_a = ($urandom_range(3) == 0) ? $urandom_range(16, 9)
                                                     : $urandom_range(8, 1);
                    len_b = ($urandom_range(3) == 0) ? $urandom_range(16, 9)
                                                     : $urandom_range(8, 1);
                    send_pair(len_a, len_b, $urandom_range(60, 20), 25);
                end
                RUN_LONG:
                begin
                    // push one side past the store depth; the other may or may not
                    if ($urandom_range(1) == 0)
                    begin
                        len_a = $urandom_range(20, 17);
                        len_b = $urandom_range(20, 1);
                    end
                    else
                    begin
                        len_a = $urandom_range(20, 1);
                        len_b = $urandom_range(20, 17);
                    end
                    send_pair(len_a, len_b, 30, 30);
                end
                RUN_MIXED:
                begin
                    n = $urandom_range(18, 2);
                    for (int i = 0; i < n; i++)
                    begin
                        sel = 1'($urandom_range(1));
                        send_elem(sel, pick_value(40),
                                  sel == SEL_A && $urandom_range(9) == 0);
                    end
                    send_elem(SEL_B, pick_value(40), 1'b1);
                end
                default:
                begin
                    // dense A segments, each restarting the position at zero
                    segs = $urandom_range(3, 2);
                    for (int s = 0; s < segs; s++)
                    begin
                        len_a = $urandom_range(10, 2);
                        for (int i = 0; i < len_a; i++)
                            send_elem(SEL_A, pick_value(10), i == len_a - 1);
                    end
                    len_b = $urandom_range(16, 1);
                    for (int i = 0; i < len_b; i++)
                        send_elem(SEL_B, pick_value(20), i == len_b - 1);
                end
            endcase
            run++;
        end

        // Drain: drop valid, wait for every predicted entry, then let the block settle
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (check_errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
